/* sv/ats_pkg.sv */
`default_nettype none

package ats_pkg;

    typedef enum logic [3:0] {
        K_EOF     = 4'd0,
        K_NEWLINE = 4'd1,
        K_REG     = 4'd2,
        K_IDENT   = 4'd3,
        K_IMM     = 4'd4,
        K_DASH    = 4'd5,
        K_STRCHAR = 4'd6,
        K_STREND  = 4'd7,
        K_COMMA   = 4'd8,
        K_LBRACK  = 4'd9,
        K_RBRACK  = 4'd10,
        K_BANG    = 4'd11,
        K_COLON   = 4'd12,
        K_DOT     = 4'd13,
        K_PERCENT = 4'd14,
        K_ERROR   = 4'd15
    } t_kind;

    // One result beat as it leaves the block.
    typedef struct packed {
        t_kind              kind;
        logic [31:0]        text_start;
        logic [15:0]        text_length;
        logic signed [31:0] imm_value;
        logic [7:0]         str_char;
        logic               last;
    } t_res;

    localparam int MaxRes = 3;

    // All results caused by one source byte, oldest in entry 0.
    typedef struct packed {
        t_res [MaxRes-1:0] res;
        logic [1:0]        cnt;
    } t_batch;

endpackage

`default_nettype wire

/* sv/ats_core.sv */
`default_nettype none

module ats_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic [7:0]     i_ch,
    output ats_pkg::t_batch     o_batch
);
    import ats_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5a;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LN     = 8'h6e;
    localparam logic [7:0] CH_LP     = 8'h70;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LW     = 8'h77;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [15:0] LenMax   = 16'hffff;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SLASH   = 9'b000000010,
        S_COMMENT = 9'b000000100,
        S_IDENT   = 9'b000001000,
        S_HASH    = 9'b000010000,
        S_SIGN    = 9'b000100000,
        S_DIGITS  = 9'b001000000,
        S_STR     = 9'b010000000,
        S_STRESC  = 9'b100000000
    } t_mode;

    // Progress toward a register spelling.
    typedef enum logic [2:0] {
        RM_NONE   = 3'd0,
        RM_XW     = 3'd1,
        RM_NUMREG = 3'd2,
        RM_S      = 3'd3,
        RM_SP     = 3'd4,
        RM_XWZ    = 3'd5,
        RM_ZR     = 3'd6
    } t_rm;

    // What a byte does when it arrives between tokens.
    typedef struct packed {
        logic        nl;
        logic        emit;
        t_kind       kind;
        t_mode       mode;
        logic        pend;
        logic        ld_tok;
        t_rm         rm;
        logic        ld_imm;
        logic [31:0] acc;
        logic        neg;
    } t_idle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || (c == CH_UNDER);
    endfunction

    function automatic t_res mk(input t_kind k, input logic [31:0] start,
                                input logic [15:0] len, input logic [31:0] imm,
                                input logic [7:0] sc);
        t_res r;
        r.kind        = k;
        r.text_start  = start;
        r.text_length = len;
        r.imm_value   = imm;
        r.str_char    = sc;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic t_idle idle_step(input logic [7:0] c, input logic pend);
        t_idle r;
        logic  starts;
        r        = '0;
        r.kind   = K_ERROR;
        r.mode   = S_IDLE;
        r.rm     = RM_NONE;
        r.pend   = pend;
        starts   = !((c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_NUL)
                     || (c == CH_SLASH));
        r.nl     = pend && starts;
        if (r.nl) begin
            r.pend = 1'b0;
        end
        if (c == CH_LF) begin
            r.pend = 1'b1;
        end else if (c == CH_NUL) begin
            r.pend = 1'b0;
            r.emit = 1'b1;
            r.kind = K_EOF;
        end else if (c == CH_SLASH) begin
            r.mode = S_SLASH;
        end else if (starts) begin
            if (is_alpha(c)) begin
                r.mode   = S_IDENT;
                r.ld_tok = 1'b1;
                r.rm     = ((c == CH_LX) || (c == CH_LW)) ? RM_XW
                         : ((c == CH_LS) ? RM_S : RM_NONE);
            end else if (is_digit(c)) begin
                r.mode   = S_DIGITS;
                r.ld_imm = 1'b1;
                r.acc    = {24'd0, c - CH_0};
            end else if (c == CH_MINUS) begin
                r.mode   = S_SIGN;
                r.ld_imm = 1'b1;
                r.neg    = 1'b1;
            end else if (c == CH_HASH) begin
                r.mode   = S_HASH;
                r.ld_imm = 1'b1;
            end else if (c == CH_QUOTE) begin
                r.mode   = S_STR;
            end else begin
                r.emit = 1'b1;
                case (c)
                    CH_COMMA:  r.kind = K_COMMA;
                    CH_LBRACK: r.kind = K_LBRACK;
                    CH_RBRACK: r.kind = K_RBRACK;
                    CH_BANG:   r.kind = K_BANG;
                    CH_COLON:  r.kind = K_COLON;
                    CH_DOT:    r.kind = K_DOT;
                    CH_PCT:    r.kind = K_PERCENT;
                    default:   r.kind = K_ERROR;
                endcase
            end
        end
        return r;
    endfunction

    t_mode       r_mode,   n_mode;
    logic        r_pend,   n_pend;
    logic [31:0] r_pos;
    logic [31:0] r_tstart, n_tstart;
    logic [15:0] r_tlen,   n_tlen;
    logic [31:0] r_acc,    n_acc;
    logic        r_neg,    n_neg;
    t_rm         r_rm,     n_rm;

    t_idle             id;
    logic              use_idle;
    logic [7:0]        dv;
    logic [31:0]       imm_out;
    logic              is_reg;
    t_res [MaxRes-1:0] res;
    logic [1:0]        cnt;
    t_rm               rm_step;

    assign dv      = i_ch - CH_0;
    assign imm_out = r_neg ? (32'd0 - r_acc) : r_acc;
    assign is_reg  = (r_rm == RM_NUMREG) || (r_rm == RM_SP) || (r_rm == RM_ZR);
    // A lone slash has already flushed the pending newline ahead of its error.
    assign id      = idle_step(i_ch, (r_mode == S_SLASH) ? 1'b0 : r_pend);

    always_comb begin
        case (r_rm)
            RM_XW:     rm_step = is_digit(i_ch) ? RM_NUMREG
                               : ((i_ch == CH_LZ) ? RM_XWZ : RM_NONE);
            RM_NUMREG: rm_step = RM_NUMREG;
            RM_S:      rm_step = (i_ch == CH_LP) ? RM_SP : RM_NONE;
            RM_XWZ:    rm_step = (i_ch == CH_LR) ? RM_ZR : RM_NONE;
            default:   rm_step = RM_NONE;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_tstart = r_tstart;
        n_tlen   = r_tlen;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_rm     = r_rm;
        res      = '0;
        cnt      = 2'd0;
        use_idle = 1'b0;

        case (r_mode)
            S_SLASH: begin
                if (i_ch == CH_SLASH) begin
                    n_mode = S_COMMENT;
                end else begin
                    if (r_pend) begin
                        res[cnt] = mk(K_NEWLINE, 32'd0, 16'd0, 32'd0, 8'd0);
                        cnt      = cnt + 2'd1;
                    end
                    res[cnt] = mk(K_ERROR, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    use_idle = 1'b1;
                end
            end
            S_COMMENT: begin
                if (i_ch == CH_LF) begin
                    n_pend = 1'b1;
                    n_mode = S_IDLE;
                end else if (i_ch == CH_NUL) begin
                    n_pend   = 1'b0;
                    n_mode   = S_IDLE;
                    res[cnt] = mk(K_EOF, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                end
            end
            S_IDENT: begin
                if (is_alpha(i_ch) || is_digit(i_ch)) begin
                    n_rm = rm_step;
                    if (r_tlen != LenMax) begin
                        n_tlen = r_tlen + 16'd1;
                    end
                end else begin
                    res[cnt] = mk(is_reg ? K_REG : K_IDENT, r_tstart, r_tlen, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    use_idle = 1'b1;
                end
            end
            S_HASH: begin
                if (i_ch == CH_MINUS) begin
                    n_mode = S_SIGN;
                    n_neg  = 1'b1;
                end else if (is_digit(i_ch)) begin
                    n_mode = S_DIGITS;
                    n_acc  = {24'd0, dv};
                end else begin
                    res[cnt] = mk(K_IMM, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    use_idle = 1'b1;
                end
            end
            S_SIGN: begin
                if (is_digit(i_ch)) begin
                    n_mode = S_DIGITS;
                    n_acc  = {24'd0, dv};
                end else begin
                    res[cnt] = mk(K_DASH, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    use_idle = 1'b1;
                end
            end
            S_DIGITS: begin
                if (is_digit(i_ch)) begin
                    n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {24'd0, dv};
                end else begin
                    res[cnt] = mk(K_IMM, 32'd0, 16'd0, imm_out, 8'd0);
                    cnt      = cnt + 2'd1;
                    use_idle = 1'b1;
                end
            end
            S_STR: begin
                if (i_ch == CH_QUOTE) begin
                    n_mode   = S_IDLE;
                    res[cnt] = mk(K_STREND, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                end else if (i_ch == CH_BSLASH) begin
                    n_mode = S_STRESC;
                end else if (i_ch == CH_NUL) begin
                    n_mode   = S_IDLE;
                    res[cnt] = mk(K_ERROR, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    res[cnt] = mk(K_EOF, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                end else begin
                    res[cnt] = mk(K_STRCHAR, 32'd0, 16'd0, 32'd0, i_ch);
                    cnt      = cnt + 2'd1;
                end
            end
            S_STRESC: begin
                if (i_ch == CH_NUL) begin
                    n_mode   = S_IDLE;
                    res[cnt] = mk(K_ERROR, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                    res[cnt] = mk(K_EOF, 32'd0, 16'd0, 32'd0, 8'd0);
                    cnt      = cnt + 2'd1;
                end else begin
                    n_mode   = S_STR;
                    res[cnt] = mk(K_STRCHAR, 32'd0, 16'd0, 32'd0,
                                  (i_ch == CH_LN) ? CH_LF
                                  : ((i_ch == CH_LT) ? CH_TAB : i_ch));
                    cnt      = cnt + 2'd1;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase

        // The token closed by this byte goes out ahead of what the byte starts.
        if (use_idle) begin
            if (id.nl) begin
                res[cnt] = mk(K_NEWLINE, 32'd0, 16'd0, 32'd0, 8'd0);
                cnt      = cnt + 2'd1;
            end
            if (id.emit) begin
                res[cnt] = mk(id.kind, 32'd0, 16'd0, 32'd0, 8'd0);
                cnt      = cnt + 2'd1;
            end
            n_mode = id.mode;
            n_pend = id.pend;
            if (id.ld_tok) begin
                n_tstart = r_pos;
                n_tlen   = 16'd1;
                n_rm     = id.rm;
            end
            if (id.ld_imm) begin
                n_acc = id.acc;
                n_neg = id.neg;
            end
        end

        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_batch.res = res;
    assign o_batch.cnt = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_IDLE;
            r_pend   <= 1'b0;
            r_pos    <= 32'd0;
            r_tstart <= 32'd0;
            r_tlen   <= 16'd0;
            r_acc    <= 32'd0;
            r_neg    <= 1'b0;
            r_rm     <= RM_NONE;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_pend   <= n_pend;
            r_pos    <= r_pos + 32'd1;
            r_tstart <= n_tstart;
            r_tlen   <= n_tlen;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_rm     <= n_rm;
        end
    end

endmodule

`default_nettype wire

/* sv/ats_obuf.sv */
`default_nettype none

module ats_obuf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire ats_pkg::t_batch i_batch,
    output logic                 o_can_load,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ats_pkg::t_res        o_item
);
    import ats_pkg::*;

    t_res [MaxRes-1:0] r_res;
    logic [1:0]        r_cnt;
    logic              pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    // A new batch may enter once the last held beat is leaving.
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (o_can_load && (i_batch.cnt != 2'd0)))
        else $error("batch loaded while the buffer still holds beats");

    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last == (r_cnt == 2'd1)))
        else $error("last flag does not mark the final beat of a batch");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_load) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("buffer count did not drop by one on a drained beat");

endmodule

`default_nettype wire

/* sv/assembly_token_scanner.sv */
// Streaming lexer for assembler text, one source byte per input beat.
// Input channel: i_valid / o_ready with the byte on i_ch; a zero byte ends
// the text and yields an EOF token, after which scanning starts afresh.
// Output channel: o_valid / i_ready, one token beat at a time; o_last marks
// the final beat caused by one source byte (a byte causes zero to three).
// Path: a taken byte waits in the input register, is scanned there, and
// its beats load into the output buffer, which offers the first of them.
// Throughput: one byte per cycle with i_ready high while each byte yields
// at most one beat; a byte with more beats holds the single output port
// until all have left, and the next byte with beats waits in the input
// register. Bytes that yield no beat pass even while the output stalls.
// Reset (synchronous, active low) empties both registers and puts the
// scanner between tokens with the byte offset at zero.
// When the receiver holds i_ready low, the current beat stays in place;
// once the input register holds a byte with beats too, o_ready drops.
`default_nettype none

module assembly_token_scanner (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_ch,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [3:0]              o_kind,
    output logic [31:0]             o_text_start,
    output logic [15:0]             o_text_length,
    output logic signed [31:0]      o_imm_value,
    output logic [7:0]              o_str_char,
    output logic                    o_last
);
    import ats_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       adv;
    logic       can_load;
    t_batch     batch;
    t_res       item;

    assign adv     = r_in_valid && ((batch.cnt == 2'd0) || can_load);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_ch <= i_ch;
        end
    end

    ats_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_ch    (r_in_ch),
        .o_batch (batch)
    );

    ats_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv && (batch.cnt != 2'd0)),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (item)
    );

    assign o_kind        = item.kind;
    assign o_text_start  = item.text_start;
    assign o_text_length = item.text_length;
    assign o_imm_value   = item.imm_value;
    assign o_str_char    = item.str_char;
    assign o_last        = item.last;

endmodule

`default_nettype wire

/* test/token_stream_checker.sv */
module token_stream_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_byte_valid,
    input  wire logic        i_byte_ready,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_tok_valid,
    input  wire logic        i_tok_ready,
    input  wire logic [3:0]  i_tok_kind,
    input  wire logic [31:0] i_tok_start,
    input  wire logic [15:0] i_tok_length,
    input  wire logic [31:0] i_tok_imm,
    input  wire logic [7:0]  i_tok_char,
    input  wire logic        i_tok_last,
    output int               o_fail_count,
    output int               o_pending
);
    import ats_pkg::*;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_IDENT,
        SCAN_HASH,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_STR,
        SCAN_STR_ESC
    } t_scan_mode;

    // Progress of an identifier toward one of the register spellings.
    typedef enum logic [2:0] {
        REGM_NONE,
        REGM_XW,
        REGM_NUMBERED,
        REGM_S,
        REGM_SP,
        REGM_XWZ,
        REGM_ZR
    } t_reg_match;

    t_scan_mode  mode;
    logic        nl_pending;
    logic [31:0] byte_pos;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [31:0] imm_acc;
    logic        imm_neg;
    t_reg_match  reg_match;

    t_res byte_toks [MaxRes];
    int   n_toks;
    t_res expected_tokens [$];

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [31:0] digit_value(logic [7:0] c);
        return 32'(c) - 32'("0");
    endfunction

    function automatic void add_token(t_kind k, logic [31:0] start, logic [15:0] len,
                                      logic [31:0] imm, logic [7:0] ch);
        t_res tok;
        tok.kind        = k;
        tok.text_start  = start;
        tok.text_length = len;
        tok.imm_value   = imm;
        tok.str_char    = ch;
        tok.last        = 1'b0;
        if (n_toks < MaxRes) begin
            byte_toks[n_toks] = tok;
            n_toks++;
        end
    endfunction

    function automatic void add_kind(t_kind k);
        add_token(k, 32'd0, 16'd0, 32'd0, 8'd0);
    endfunction

    function automatic void flush_newline();
        if (nl_pending) begin
            add_kind(K_NEWLINE);
            nl_pending = 1'b0;
        end
    endfunction

    function automatic t_reg_match advance_match(t_reg_match m, logic [7:0] c);
        case (m)
            REGM_XW:       return is_digit(c) ? REGM_NUMBERED : (c == "z" ? REGM_XWZ : REGM_NONE);
            REGM_NUMBERED: return REGM_NUMBERED;
            REGM_S:        return c == "p" ? REGM_SP : REGM_NONE;
            REGM_XWZ:      return c == "r" ? REGM_ZR : REGM_NONE;
            default:       return REGM_NONE;
        endcase
    endfunction

    // A byte seen between tokens, or the byte that just closed one.
    function automatic void scan_idle(logic [7:0] c);
        mode = SCAN_IDLE;
        if (c == "\n") begin
            nl_pending = 1'b1;
        end else if (c == 8'h00) begin
            nl_pending = 1'b0;
            add_kind(K_EOF);
        end else if (c == "/") begin
            mode = SCAN_SLASH;
        end else if (c != " " && c != "\t") begin
            flush_newline();
            if (is_alpha(c)) begin
                mode      = SCAN_IDENT;
                tok_start = byte_pos;
                tok_len   = 16'd1;
                reg_match = (c == "x" || c == "w") ? REGM_XW : (c == "s" ? REGM_S : REGM_NONE);
            end else if (is_digit(c)) begin
                mode    = SCAN_DIGITS;
                imm_acc = digit_value(c);
                imm_neg = 1'b0;
            end else begin
                case (c)
                    "-": begin
                        mode    = SCAN_SIGN;
                        imm_acc = 32'd0;
                        imm_neg = 1'b1;
                    end
                    "#": begin
                        mode    = SCAN_HASH;
                        imm_acc = 32'd0;
                        imm_neg = 1'b0;
                    end
                    "\"":    mode = SCAN_STR;
                    ",":     add_kind(K_COMMA);
                    "[":     add_kind(K_LBRACK);
                    "]":     add_kind(K_RBRACK);
                    "!":     add_kind(K_BANG);
                    ":":     add_kind(K_COLON);
                    ".":     add_kind(K_DOT);
                    "%":     add_kind(K_PERCENT);
                    default: add_kind(K_ERROR);
                endcase
            end
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic is_reg;
        n_toks = 0;
        case (mode)
            SCAN_SLASH: begin
                if (c == "/") begin
                    mode = SCAN_COMMENT;
                end else begin
                    flush_newline();
                    add_kind(K_ERROR);
                    scan_idle(c);
                end
            end
            SCAN_COMMENT: begin
                if (c == "\n") begin
                    nl_pending = 1'b1;
                    mode       = SCAN_IDLE;
                end else if (c == 8'h00) begin
                    nl_pending = 1'b0;
                    mode       = SCAN_IDLE;
                    add_kind(K_EOF);
                end
            end
            SCAN_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    reg_match = advance_match(reg_match, c);
                    if (tok_len != 16'hffff) tok_len++;
                end else begin
                    is_reg = reg_match == REGM_NUMBERED || reg_match == REGM_SP
                          || reg_match == REGM_ZR;
                    add_token(is_reg ? K_REG : K_IDENT, tok_start, tok_len, 32'd0, 8'd0);
                    scan_idle(c);
                end
            end
            SCAN_HASH: begin
                if (c == "-") begin
                    mode    = SCAN_SIGN;
                    imm_neg = 1'b1;
                end else if (is_digit(c)) begin
                    mode    = SCAN_DIGITS;
                    imm_acc = digit_value(c);
                end else begin
                    add_kind(K_IMM);
                    scan_idle(c);
                end
            end
            SCAN_SIGN: begin
                if (is_digit(c)) begin
                    mode    = SCAN_DIGITS;
                    imm_acc = digit_value(c);
                end else begin
                    add_kind(K_DASH);
                    scan_idle(c);
                end
            end
            SCAN_DIGITS: begin
                if (is_digit(c)) begin
                    imm_acc = imm_acc * 32'd10 + digit_value(c);
                end else begin
                    add_token(K_IMM, 32'd0, 16'd0, imm_neg ? 32'd0 - imm_acc : imm_acc, 8'd0);
                    scan_idle(c);
                end
            end
            SCAN_STR: begin
                if (c == "\"") begin
                    mode = SCAN_IDLE;
                    add_kind(K_STREND);
                end else if (c == "\\") begin
                    mode = SCAN_STR_ESC;
                end else if (c == 8'h00) begin
                    mode = SCAN_IDLE;
                    add_kind(K_ERROR);
                    add_kind(K_EOF);
                end else begin
                    add_token(K_STRCHAR, 32'd0, 16'd0, 32'd0, c);
                end
            end
            SCAN_STR_ESC: begin
                if (c == 8'h00) begin
                    mode = SCAN_IDLE;
                    add_kind(K_ERROR);
                    add_kind(K_EOF);
                end else begin
                    mode = SCAN_STR;
                    add_token(K_STRCHAR, 32'd0, 16'd0, 32'd0,
                              c == "n" ? 8'd10 : (c == "t" ? 8'd9 : c));
                end
            end
            default: scan_idle(c);
        endcase

        if (n_toks > 0) byte_toks[n_toks - 1].last = 1'b1;
        for (int i = 0; i < n_toks; i++) expected_tokens.push_back(byte_toks[i]);
        byte_pos++;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    function automatic void check_token();
        t_res want;
        if (expected_tokens.size() == 0) begin
            $error("token beat with nothing expected: kind %0d", i_tok_kind);
            o_fail_count++;
        end else begin
            want = expected_tokens.pop_front();
            check_field("kind", 32'(want.kind), 32'(i_tok_kind));
            check_field("text_start", want.text_start, i_tok_start);
            check_field("text_length", 32'(want.text_length), 32'(i_tok_length));
            check_field("imm_value", want.imm_value, i_tok_imm);
            check_field("str_char", 32'(want.str_char), 32'(i_tok_char));
            check_field("last", 32'(want.last), 32'(i_tok_last));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode       = SCAN_IDLE;
            nl_pending = 1'b0;
            byte_pos   = 32'd0;
            tok_start  = 32'd0;
            tok_len    = 16'd0;
            imm_acc    = 32'd0;
            imm_neg    = 1'b0;
            reg_match  = REGM_NONE;
            expected_tokens.delete();
            o_fail_count = 0;
        end else begin
            // A byte's tokens leave only after the byte has passed the input register
            // and the output buffer, so predicting first never races the compare.
            if (i_byte_valid && i_byte_ready) scan_byte(i_byte);
            if (i_tok_valid && i_tok_ready) check_token();
        end
        o_pending = expected_tokens.size();
    end

endmodule

/* test/tb_assembly_token_scanner.sv */
module tb_assembly_token_scanner;

    localparam int StallLimit       = 3000;
    localparam int RandomBytes      = 360;
    localparam int LongHoldCycles   = 150;

    localparam string AlphaChars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string DigitChars = "0123456789";

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_ch;
    logic               o_valid;
    logic               i_ready;
    logic [3:0]         o_kind;
    logic [31:0]        o_text_start;
    logic [15:0]        o_text_length;
    logic signed [31:0] o_imm_value;
    logic [7:0]         o_str_char;
    logic               o_last;

    int         fail_count;
    int         pending;
    logic [7:0] src_text [$];
    int         burst_left;
    int         hold_requests;
    int         random_sent;
    int         idle_cycles;

    always #1 i_clk = ~i_clk;

    assembly_token_scanner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ch          (i_ch),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_text_start  (o_text_start),
        .o_text_length (o_text_length),
        .o_imm_value   (o_imm_value),
        .o_str_char    (o_str_char),
        .o_last        (o_last)
    );

    token_stream_checker token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_valid),
        .i_byte_ready (o_ready),
        .i_byte       (i_ch),
        .i_tok_valid  (o_valid),
        .i_tok_ready  (i_ready),
        .i_tok_kind   (o_kind),
        .i_tok_start  (o_text_start),
        .i_tok_length (o_text_length),
        .i_tok_imm    (o_imm_value),
        .i_tok_char   (o_str_char),
        .i_tok_last   (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall density changes every so often; a hold request from the
    // stimulus freezes the token channel for a long stretch.
    initial begin : token_receiver
        int hold_left;
        int mode_left;
        int stall_pct;
        int hold_seen;
        hold_left = 0;
        mode_left = 0;
        stall_pct = 0;
        hold_seen = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LongHoldCycles;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(16, 160);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Called just after a rising edge; returns at the edge that takes the beat.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_ch    <= c;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic feed_text();
        foreach (src_text[i]) send_byte(src_text[i]);
        src_text.delete();
    endtask

    task automatic wait_drained();
        i_valid    <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic void put(logic [7:0] c);
        src_text.push_back(c);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void gen_space();
        case ($urandom_range(0, 5))
            3:       put("\t");
            4:       ;
            5:       put_str("  ");
            default: put(" ");
        endcase
    endfunction

    function automatic void gen_word();
        case ($urandom_range(0, 7))
            0: begin
                put(pick("xw"));
                repeat ($urandom_range(1, 2)) put(pick(DigitChars));
            end
            1: put_str("sp");
            2: put_str($urandom_range(0, 1) ? "xzr" : "wzr");
            3: begin
                // Near misses of the register spellings.
                put(pick("xws"));
                repeat ($urandom_range(0, 3)) put(pick("zrpx0_"));
            end
            4: begin
                case ($urandom_range(0, 3))
                    0:       put_str("X3");
                    1:       put_str("SP");
                    2:       put_str("Wzr");
                    default: put_str("xZR");
                endcase
            end
            default: begin
                put(pick(AlphaChars));
                repeat ($urandom_range(0, 7)) begin
                    put($urandom_range(0, 3) == 0 ? pick(DigitChars) : pick(AlphaChars));
                end
            end
        endcase
    endfunction

    function automatic void gen_imm();
        int   ndig;
        logic hash;
        logic neg;
        hash = 1'($urandom_range(0, 1));
        neg  = ($urandom_range(0, 3) == 0);
        // Long digit runs wrap the 32-bit value.
        ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
        if (!hash && !neg && ndig == 0) ndig = 1;
        if (hash) put("#");
        if (neg) put("-");
        repeat (ndig) put(pick(DigitChars));
    endfunction

    function automatic void gen_string();
        logic [7:0] c;
        put("\"");
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
                0: begin
                    put("\\");
                    put(pick("nt\\\"q"));
                end
                1: begin
                    put("\\");
                    put(8'($urandom_range(1, 255)));
                end
                default: begin
                    c = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
                                                    : 8'($urandom_range(32, 126));
                    if (c == "\"" || c == "\\") c = "?";
                    put(c);
                end
            endcase
        end
        case ($urandom_range(0, 11))
            0: put(8'h00);
            1: begin
                put("\\");
                put(8'h00);
            end
            default: put("\"");
        endcase
    endfunction

    function automatic void gen_comment();
        logic [7:0] c;
        put_str("//");
        repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(1, 255));
            put(c == "\n" ? 8'("c") : c);
        end
        put($urandom_range(0, 7) == 0 ? 8'h00 : 8'("\n"));
    endfunction

    function automatic void gen_operand();
        case ($urandom_range(0, 7))
            0, 1: gen_word();
            2, 3: gen_imm();
            4: begin
                put("[");
                gen_word();
                if ($urandom_range(0, 1)) begin
                    put(",");
                    gen_space();
                    gen_imm();
                end
                put("]");
                if ($urandom_range(0, 1)) put("!");
            end
            5: gen_string();
            6: begin
                put(pick("%.:"));
                gen_word();
            end
            default: put(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // One assembler line; most are well formed, a few carry stray bytes.
    function automatic void gen_line();
        int nops;
        if ($urandom_range(0, 5) == 0) begin
            gen_word();
            put(":");
            gen_space();
        end
        if ($urandom_range(0, 6) == 0) put(".");
        gen_word();
        nops = $urandom_range(0, 3);
        for (int i = 0; i < nops; i++) begin
            if (i > 0) begin
                put(",");
                gen_space();
            end else begin
                put(" ");
            end
            gen_operand();
        end
        if ($urandom_range(0, 4) == 0) begin
            gen_space();
            gen_comment();
        end else begin
            repeat ($urandom_range(1, 2)) put("\n");
        end
        if ($urandom_range(0, 7) == 0) put(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 11) == 0) put("/");
        if ($urandom_range(0, 9) == 0) put(8'h00);
    endfunction

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_ch          <= 8'h00;
        burst_left    = 0;
        hold_requests = 0;
        random_sent   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Leading newline, uppercase non-register, every punctuation mark, a
        // lone slash, bare minus and bare hash, escapes, a top-bit byte,
        // newline dropped at end of text, and an unterminated string.
        put_str("\nX1,sp:#-9[w7]!.%/a-#\"\\n\\t");
        put(8'hff);
        put_str("\"\n");
        put(8'h00);
        put("\"");
        put(8'h00);
        feed_text();
        wait_drained();

        // Token channel frozen while commas keep coming: the block backs up.
        hold_requests++;
        put_str(",,,,,,,,,,,,x0 ");
        feed_text();
        wait_drained();

        while (random_sent < RandomBytes) begin
            gen_line();
            random_sent += src_text.size();
            feed_text();
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        // Close whatever token is still open.
        put(8'h00);
        feed_text();
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
